// ===== sv/spda_pkg.sv =====
// spda_pkg: shared types and constants for the stereo pan / distance attenuator
// no dependencies
`timescale 1ns / 1ps

package spda_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_LISTENER_X = 3'd0;
  localparam logic [2:0] REG_LISTENER_Y = 3'd1;
  localparam logic [2:0] REG_LISTENER_Z = 3'd2;
  localparam logic [2:0] REG_RIGHT_X    = 3'd3;
  localparam logic [2:0] REG_RIGHT_Y    = 3'd4;
  localparam logic [2:0] REG_RIGHT_Z    = 3'd5;
  localparam logic [2:0] REG_MONO       = 3'd6;

  localparam int SQRT_STAGES = 33;  // one root bit per stage
  localparam int DIV_STAGES  = 18;  // pan quotient stays below 2^17

  localparam logic signed [19:0] ONE_Q14 = 20'sd16384;
  localparam logic signed [41:0] ONE_Q24 = 42'sd16777216;

  // fields that ride along the pipe up to volume stage 3
  typedef struct packed {
    logic        view;
    logic [7:0]  master;
    logic [23:0] factor;
  } item_t;

endpackage

// ===== sv/stereo_pan_distance_attenuator.sv =====
// stereo_pan_distance_attenuator: per-source left/right volume from position
// depends on spda_pkg
// pipeline: 3 vector stages, 33 root stages, 18 quotient stages, 3 volume stages,
//   output register
// throughput: one word per cycle while the skid register is empty, set by the one-bit-per-stage root and divider
// a skid register behind the pipe keeps in_tready independent of out_tready
// reset (synchronous, rst_n low) clears all valid bits; config returns to
//   listener at origin, right vector (1,0,0), stereo
`timescale 1ns / 1ps

module stereo_pan_distance_attenuator (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // master_volume[7:0], source_x[39:8], source_y[71:40], source_z[103:72],
  // distance_factor[127:104]
  input  logic [127:0] in_tdata,
  // is_view_entity[0]
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // left_volume[8:0], right_volume[17:9], zero[23:18]
  output logic [23:0]  out_tdata
);

  localparam int NS = spda_pkg::SQRT_STAGES;
  localparam int ND = spda_pkg::DIV_STAGES;

  // configuration
  logic signed [31:0] lx_r, ly_r, lz_r;
  logic signed [15:0] rx_r, ry_r, rz_r;
  logic               mono_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lx_r <= '0; ly_r <= '0; lz_r <= '0;
      rx_r <= 16'sd16384; ry_r <= '0; rz_r <= '0;
      mono_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        spda_pkg::REG_LISTENER_X: lx_r <= cfg_data;
        spda_pkg::REG_LISTENER_Y: ly_r <= cfg_data;
        spda_pkg::REG_LISTENER_Z: lz_r <= cfg_data;
        spda_pkg::REG_RIGHT_X:    rx_r <= cfg_data[15:0];
        spda_pkg::REG_RIGHT_Y:    ry_r <= cfg_data[15:0];
        spda_pkg::REG_RIGHT_Z:    rz_r <= cfg_data[15:0];
        spda_pkg::REG_MONO:       mono_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic skid_v_r;
  logic en;
  assign en        = !skid_v_r;
  assign in_tready = en;

  // stage 1: offset vector
  logic               v1_r;
  spda_pkg::item_t    it1_r;
  logic signed [32:0] vx1_r, vy1_r, vz1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      it1_r.view   <= in_tuser;
      it1_r.master <= in_tdata[7:0];
      it1_r.factor <= in_tdata[127:104];
      vx1_r <= {in_tdata[39], in_tdata[39:8]}    - {lx_r[31], lx_r};
      vy1_r <= {in_tdata[71], in_tdata[71:40]}   - {ly_r[31], ly_r};
      vz1_r <= {in_tdata[103], in_tdata[103:72]} - {lz_r[31], lz_r};
    end
  end

  // stage 2: squares and dot product terms
  logic               v2_r;
  spda_pkg::item_t    it2_r;
  logic [63:0]        sqx2_r, sqy2_r, sqz2_r;
  logic signed [48:0] dx2_r, dy2_r, dz2_r;
  logic [32:0]        ax, ay, az;

  always_comb begin
    ax = vx1_r[32] ? 33'(-vx1_r) : vx1_r;
    ay = vy1_r[32] ? 33'(-vy1_r) : vy1_r;
    az = vz1_r[32] ? 33'(-vz1_r) : vz1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      it2_r  <= it1_r;
      sqx2_r <= ax[31:0] * ax[31:0];
      sqy2_r <= ay[31:0] * ay[31:0];
      sqz2_r <= az[31:0] * az[31:0];
      dx2_r  <= rx_r * vx1_r;
      dy2_r  <= ry_r * vy1_r;
      dz2_r  <= rz_r * vz1_r;
    end
  end

  // root pipe, index 0 is the sum stage
  logic               sq_v_r    [0:NS];
  spda_pkg::item_t    sq_it_r   [0:NS];
  logic [65:0]        sq_rad_r  [0:NS];
  logic [35:0]        sq_rem_r  [0:NS];
  logic [32:0]        sq_root_r [0:NS];
  logic signed [50:0] sq_p_r    [0:NS];

  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r[0] <= 1'b0;
    else if (en) sq_v_r[0] <= v2_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sq_it_r[0]   <= it2_r;
      sq_rad_r[0]  <= {2'b00, sqx2_r} + {2'b00, sqy2_r} + {2'b00, sqz2_r};
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_p_r[0]    <= 51'(dx2_r) + 51'(dy2_r) + 51'(dz2_r);
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    logic [35:0] rem_in, trial;
    logic        ge;
    assign rem_in = {sq_rem_r[k][33:0], sq_rad_r[k][65:64]};
    assign trial  = {1'b0, sq_root_r[k], 2'b01};
    assign ge     = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[k+1] <= 1'b0;
      else if (en) sq_v_r[k+1] <= sq_v_r[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_it_r[k+1]   <= sq_it_r[k];
        sq_p_r[k+1]    <= sq_p_r[k];
        sq_rad_r[k+1]  <= {sq_rad_r[k][63:0], 2'b00};
        sq_rem_r[k+1]  <= ge ? rem_in - trial : rem_in;
        sq_root_r[k+1] <= {sq_root_r[k][31:0], ge};
      end
    end
  end

  // quotient pipe: |p| / L, one bit per stage from the top
  logic               dv_v_r   [0:ND-1];
  spda_pkg::item_t    dv_it_r  [0:ND-1];
  logic [50:0]        dv_rem_r [0:ND-1];
  logic [17:0]        dv_q_r   [0:ND-1];
  logic [32:0]        dv_len_r [0:ND-1];
  logic               dv_neg_r [0:ND-1];

  for (genvar j = 0; j < ND; j++) begin : g_div
    localparam int SH = ND - 1 - j;
    logic            v_in, neg_in;
    spda_pkg::item_t it_in;
    logic [50:0]     rem_in, trial;
    logic [17:0]     q_in;
    logic [32:0]     len_in;
    logic            ge;

    if (j == 0) begin : g_first
      assign v_in   = sq_v_r[NS];
      assign it_in  = sq_it_r[NS];
      assign neg_in = sq_p_r[NS][50];
      assign rem_in = sq_p_r[NS][50] ? 51'(-sq_p_r[NS]) : sq_p_r[NS];
      assign q_in   = '0;
      assign len_in = sq_root_r[NS];
    end else begin : g_next
      assign v_in   = dv_v_r[j-1];
      assign it_in  = dv_it_r[j-1];
      assign neg_in = dv_neg_r[j-1];
      assign rem_in = dv_rem_r[j-1];
      assign q_in   = dv_q_r[j-1];
      assign len_in = dv_len_r[j-1];
    end

    assign trial = 51'(len_in) << SH;
    assign ge    = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[j] <= 1'b0;
      else if (en) dv_v_r[j] <= v_in;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_it_r[j]  <= it_in;
        dv_neg_r[j] <= neg_in;
        dv_len_r[j] <= len_in;
        dv_rem_r[j] <= ge ? rem_in - trial : rem_in;
        dv_q_r[j]   <= {q_in[16:0], ge};
      end
    end
  end

  // volume stage 1: pan, attenuation, master times pan
  logic               e1_v_r;
  spda_pkg::item_t    e1_it_r;
  logic signed [41:0] e1_att_r;
  logic signed [28:0] e1_ml_r, e1_mr_r;
  logic signed [18:0] d_c;
  logic signed [19:0] pan_l, pan_r;
  logic [56:0]        dist_full;

  always_comb begin
    d_c = dv_neg_r[ND-1] ? -$signed({1'b0, dv_q_r[ND-1]}) : $signed({1'b0, dv_q_r[ND-1]});
    if (dv_len_r[ND-1] == '0) d_c = '0;
    if (mono_r) begin
      pan_l = spda_pkg::ONE_Q14;
      pan_r = spda_pkg::ONE_Q14;
    end else begin
      pan_l = spda_pkg::ONE_Q14 - 20'(d_c);
      pan_r = spda_pkg::ONE_Q14 + 20'(d_c);
    end
    dist_full = dv_len_r[ND-1] * dv_it_r[ND-1].factor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) e1_v_r <= 1'b0;
    else if (en) e1_v_r <= dv_v_r[ND-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e1_it_r  <= dv_it_r[ND-1];
      e1_att_r <= spda_pkg::ONE_Q24 - $signed({1'b0, dist_full[56:16]});
      e1_ml_r  <= $signed({1'b0, dv_it_r[ND-1].master}) * pan_l;
      e1_mr_r  <= $signed({1'b0, dv_it_r[ND-1].master}) * pan_r;
    end
  end

  // volume stage 2: magnitudes, sign check, partial products
  logic            e2_v_r;
  spda_pkg::item_t e2_it_r;
  logic            e2_zl_r, e2_zr_r;
  logic [48:0]     e2_lhi_r, e2_llo_r, e2_rhi_r, e2_rlo_r;
  logic [41:0]     ua;
  logic [28:0]     uml, umr;

  always_comb begin
    ua  = e1_att_r[41] ? 42'(-e1_att_r) : e1_att_r;
    uml = e1_ml_r[28] ? 29'(-e1_ml_r) : e1_ml_r;
    umr = e1_mr_r[28] ? 29'(-e1_mr_r) : e1_mr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) e2_v_r <= 1'b0;
    else if (en) e2_v_r <= e1_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e2_it_r  <= e1_it_r;
      // zero product or opposite signs give no volume
      e2_zl_r  <= (e1_ml_r == '0) || (e1_att_r == '0) || (e1_ml_r[28] != e1_att_r[41]);
      e2_zr_r  <= (e1_mr_r == '0) || (e1_att_r == '0) || (e1_mr_r[28] != e1_att_r[41]);
      e2_lhi_r <= ua[41:21] * uml[27:0];
      e2_llo_r <= ua[20:0]  * uml[27:0];
      e2_rhi_r <= ua[41:21] * umr[27:0];
      e2_rlo_r <= ua[20:0]  * umr[27:0];
    end
  end

  // volume stage 3: combine, scale, saturate, zero or view-entity override
  logic        fin_v_r;
  logic [8:0]  fin_l_r, fin_r_r;
  logic [69:0] prod_l, prod_r;
  logic [8:0]  vol_l, vol_r;

  always_comb begin
    prod_l = {e2_lhi_r, 21'b0} + 70'(e2_llo_r);
    prod_r = {e2_rhi_r, 21'b0} + 70'(e2_rlo_r);
    vol_l  = (|prod_l[69:47]) ? 9'h1FF : prod_l[46:38];
    vol_r  = (|prod_r[69:47]) ? 9'h1FF : prod_r[46:38];
    if (e2_zl_r) vol_l = '0;
    if (e2_zr_r) vol_r = '0;
    if (e2_it_r.view) begin
      vol_l = {1'b0, e2_it_r.master};
      vol_r = {1'b0, e2_it_r.master};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fin_v_r <= 1'b0;
    else if (en) fin_v_r <= e2_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      fin_l_r <= vol_l;
      fin_r_r <= vol_r;
    end
  end

  // output register with skid
  logic        out_v_r;
  logic [17:0] out_d_r, skid_d_r;
  logic        pipe_put;
  assign pipe_put = en && fin_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && !out_tready) begin
      if (pipe_put) skid_v_r <= 1'b1;
    end else if (skid_v_r) begin
      out_v_r  <= 1'b1;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= pipe_put;
    end
  end
  always_ff @(posedge clk) begin
    if (out_v_r && !out_tready) begin
      if (pipe_put) skid_d_r <= {fin_r_r, fin_l_r};
    end else if (skid_v_r) begin
      out_d_r <= skid_d_r;
    end else begin
      out_d_r <= {fin_r_r, fin_l_r};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'b0, out_d_r};

  // a word in the skid always has one ahead of it
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a word while output is empty");

  // a full skid with a stalled output keeps its word
  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_tready |=> skid_v_r && $stable(skid_d_r))
    else $error("skid word lost under stall");

  // reset leaves nothing to deliver
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_v_r && !skid_v_r && !fin_v_r)
    else $error("valid state survived reset");

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for stereo_pan_distance_attenuator
// depends on spda_pkg and the block; predicts left/right volumes per source word
`timescale 1ns / 1ps

module tb_top;

  localparam logic [2:0] REG_UNUSED = 3'd7;  // index past the register list
  localparam int LATENCY = 70;

  typedef struct {
    bit               view;
    bit [7:0]         master;
    bit signed [31:0] sx, sy, sz;
    bit [23:0]        factor;
  } source_t;

  class volume_scoreboard;
    longint lst_x, lst_y, lst_z, rgt_x, rgt_y, rgt_z;
    bit     mono;
    bit [8:0] want_left[$];
    bit [8:0] want_right[$];
    int errors;

    function new();
      lst_x = 0; lst_y = 0; lst_z = 0;
      rgt_x = 16384; rgt_y = 0; rgt_z = 0;
      mono = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        spda_pkg::REG_LISTENER_X: lst_x = longint'($signed(val));
        spda_pkg::REG_LISTENER_Y: lst_y = longint'($signed(val));
        spda_pkg::REG_LISTENER_Z: lst_z = longint'($signed(val));
        spda_pkg::REG_RIGHT_X:    rgt_x = longint'($signed(val[15:0]));
        spda_pkg::REG_RIGHT_Y:    rgt_y = longint'($signed(val[15:0]));
        spda_pkg::REG_RIGHT_Z:    rgt_z = longint'($signed(val[15:0]));
        spda_pkg::REG_MONO:       mono  = val[0];
        default: ;
      endcase
    endfunction

    // floor(master*att*pan / 2^38) of the exact product, zero unless positive
    function bit [8:0] scaled_volume(longint master, longint att, longint pan);
      longint m, um, ua;
      logic [127:0] prod;
      m = master * pan;
      if (m == 0 || att == 0) return 0;
      if ((m < 0) != (att < 0)) return 0;
      um = m < 0 ? -m : m;
      ua = att < 0 ? -att : att;
      prod = 128'(ua) * 128'(um);
      prod = prod >> 38;
      return prod > 511 ? 9'd511 : prod[8:0];
    endfunction

    function void note_source(source_t s);
      longint vx, vy, vz, len, dst, att, p, d, rpan, lpan;
      logic [67:0] sum, root, t;
      if (s.view) begin
        want_left.push_back({1'b0, s.master});
        want_right.push_back({1'b0, s.master});
        return;
      end
      vx = longint'(s.sx) - lst_x;
      vy = longint'(s.sy) - lst_y;
      vz = longint'(s.sz) - lst_z;
      sum = 68'(vx * vx) + 68'(vy * vy) + 68'(vz * vz);
      // squares may exceed 63 bits, redo them wide
      sum = 68'($unsigned(vx < 0 ? -vx : vx)) * 68'($unsigned(vx < 0 ? -vx : vx))
          + 68'($unsigned(vy < 0 ? -vy : vy)) * 68'($unsigned(vy < 0 ? -vy : vy))
          + 68'($unsigned(vz < 0 ? -vz : vz)) * 68'($unsigned(vz < 0 ? -vz : vz));
      root = 0;
      for (int b = 32; b >= 0; b--) begin
        t = root | (68'd1 << b);
        if (t * t <= sum) root = t;
      end
      len = longint'(root);
      dst = (len * longint'(s.factor)) >>> 16;
      att = 64'sd16777216 - dst;
      p = rgt_x * vx + rgt_y * vy + rgt_z * vz;
      d = (len == 0) ? 0 : p / len;
      if (mono) begin
        rpan = 16384; lpan = 16384;
      end else begin
        rpan = 16384 + d; lpan = 16384 - d;
      end
      want_left.push_back(scaled_volume(s.master, att, lpan));
      want_right.push_back(scaled_volume(s.master, att, rpan));
    endfunction

    function void check_volumes(bit [8:0] left, bit [8:0] right);
      bit [8:0] el, er;
      if (want_left.size() == 0) begin
        $error("unexpected output word left=%0d right=%0d", left, right);
        errors++;
        return;
      end
      el = want_left.pop_front();
      er = want_right.pop_front();
      if (left !== el) begin
        $error("left_volume expected %0d actual %0d", el, left);
        errors++;
      end
      if (right !== er) begin
        $error("right_volume expected %0d actual %0d", er, right);
        errors++;
      end
    endfunction

    function int pending();
      return want_left.size();
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [2:0]   cfg_addr;
  logic [31:0]  cfg_data;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [23:0]  out_tdata;

  volume_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;

  stereo_pan_distance_attenuator uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // accepted words and delivered output words, sampled with pre-edge values
  always @(posedge clk) begin
    source_t s;
    if (rst_n && in_tvalid && in_tready) begin
      s.view   = in_tuser;
      s.master = in_tdata[7:0];
      s.sx     = in_tdata[39:8];
      s.sy     = in_tdata[71:40];
      s.sz     = in_tdata[103:72];
      s.factor = in_tdata[127:104];
      sb.note_source(s);
    end
    if (rst_n && out_tvalid && out_tready)
      sb.check_volumes(out_tdata[8:0], out_tdata[17:9]);
  end

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_regs(logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
                            logic [15:0] rx, logic [15:0] ry, logic [15:0] rz,
                            bit mono_on);
    logic [31:0] vals [7];
    vals = '{lx, ly, lz, {{16{rx[15]}}, rx}, {{16{ry[15]}}, ry}, {{16{rz[15]}}, rz},
             {31'd0, mono_on}};
    for (int i = 0; i < 7; i++) begin
      @(posedge clk);
      cfg_we   <= 1'b1;
      cfg_addr <= 3'(i);
      cfg_data <= vals[i];
      sb.set_reg(3'(i), vals[i]);
    end
    // a stray index must not disturb anything
    @(posedge clk);
    cfg_addr <= REG_UNUSED;
    cfg_data <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_source(source_t s);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= s.view;
    in_tdata  <= {s.factor, s.sz, s.sy, s.sx, s.master};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic source_t random_source();
    source_t s;
    int kind;
    kind = $urandom_range(99);
    s.view   = ($urandom_range(9) == 0);
    s.master = ($urandom_range(9) == 0) ? 8'd255 : 8'($urandom);
    if (kind < 70) begin
      // near the listener with a distance factor of at most 2^20
      s.sx = 32'(sb.lst_x + $signed(32'($urandom_range(0, 2 ** 22)) - 32'(2 ** 21)));
      s.sy = 32'(sb.lst_y + $signed(32'($urandom_range(0, 2 ** 22)) - 32'(2 ** 21)));
      s.sz = 32'(sb.lst_z + $signed(32'($urandom_range(0, 2 ** 22)) - 32'(2 ** 21)));
      s.factor = 24'($urandom_range(0, 2 ** 20));
    end else if (kind < 85) begin
      s.sx = 32'(sb.lst_x + $signed(32'($urandom_range(0, 2 ** 10)) - 32'(2 ** 9)));
      s.sy = 32'(sb.lst_y);
      s.sz = 32'(sb.lst_z + $signed(32'($urandom_range(0, 2 ** 10)) - 32'(2 ** 9)));
      s.factor = 24'($urandom);
    end else begin
      s.sx = $urandom; s.sy = $urandom; s.sz = $urandom;
      s.factor = 24'($urandom);
    end
    return s;
  endfunction

  function automatic source_t mk(bit view, bit [7:0] master, bit [31:0] x, bit [31:0] y,
                                 bit [31:0] z, bit [23:0] factor);
    source_t s;
    s.view = view; s.master = master; s.sx = x; s.sy = y; s.sz = z; s.factor = factor;
    return s;
  endfunction

  initial begin
    source_t s;
    int idle_mode [4][2];
    sb = new();
    idle_mode = '{'{0, 0}, '{48, 0}, '{0, 48}, '{21, 21}};
    send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_addr = '0; cfg_data = '0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = 1'b0; out_tready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset registers, listener at origin, right vector along +x
    send_source(mk(1, 8'd255, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 24'hffffff));
    send_source(mk(1, 8'd0, 32'h0, 32'h0, 32'h0, 24'h0));
    send_source(mk(0, 8'd255, 32'h0, 32'h0, 32'h0, 24'hffffff));
    send_source(mk(0, 8'd255, 32'h0001_0000, 32'h0, 32'h0, 24'h0));
    send_source(mk(0, 8'd255, 32'hffff_0000, 32'h0, 32'h0, 24'h0));
    send_source(mk(0, 8'd255, 32'h0, 32'h0001_0000, 32'h0, 24'h0));
    send_source(mk(0, 8'd128, 32'h0002_0000, 32'h0, 32'h0, 24'h40_0000));
    send_source(mk(0, 8'd255, 32'h0010_0000, 32'h0, 32'h0, 24'h10_0000));
    send_source(mk(0, 8'd255, 32'h0100_0000, 32'h0, 32'h0, 24'h10_0000));
    send_source(mk(0, 8'd255, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 24'h0));
    send_source(mk(0, 8'd255, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'h1));
    send_source(mk(0, 8'd0, 32'h0003_0000, 32'h0004_0000, 32'h0, 24'h0));
    send_source(mk(0, 8'd255, 32'h0000_0001, 32'h0, 32'h0, 24'hffffff));
    settle();
    // right vector out of unit range, listener at the far corner
    write_regs(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
               16'h8000, 16'h7fff, 16'h8000, 1'b0);
    send_source(mk(0, 8'd255, 32'h8001_0000, 32'h7fff_ffff, 32'h8000_0000, 24'h0));
    send_source(mk(0, 8'd255, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 24'h0));
    send_source(mk(0, 8'd200, 32'h8000_0000, 32'h7ffe_0000, 32'h8000_1000, 24'h1000));
    settle();
    write_regs(32'h0, 32'h0, 32'h0, 16'd16384, 16'd0, 16'd0, 1'b1);
    send_source(mk(0, 8'd255, 32'h0002_0000, 32'h0, 32'h0, 24'h1_0000));
    send_source(mk(0, 8'd255, 32'hfffe_0000, 32'h0, 32'h0, 24'h80_0000));
    send_source(mk(0, 8'd255, 32'h0, 32'h0, 32'h0, 24'h0));
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: write_regs($urandom, $urandom, $urandom, 16'd16384, 16'd0, 16'd0, 1'b0);
        1: write_regs(32'h7fff_ffff, 32'h8000_0000, 32'h0, 16'hc000, 16'd0, 16'd0,
                      1'b0);
        2: write_regs($urandom, $urandom, $urandom, 16'($urandom_range(0, 32768) - 16384),
                      16'($urandom_range(0, 32768) - 16384),
                      16'($urandom_range(0, 32768) - 16384), 1'($urandom));
        default: write_regs($urandom, $urandom, $urandom, 16'd0, 16'd11585, 16'hd2bf,
                            1'b0);
      endcase
      send_idle_pct  = idle_mode[ph % 4][0];
      recv_stall_pct = idle_mode[ph % 4][1];
      if (ph == 1) hold_cycles = 400;  // back up the pipe while words keep coming
      for (int i = 0; i < 170; i++) begin
        if (ph == 2 && i == 85) begin
          in_tvalid <= 1'b0;
          while (sb.pending() != 0) @(posedge clk);
        end
        send_source(random_source());
      end
      settle();
    end

    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
